FILE: hw/rtl/cofd_pkg.sv
// Shared types, codes and decode functions for the CANopen frame decoder.
// No dependencies; the front, queue, back and top modules refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cofd_pkg;

  localparam int unsigned MaxFieldsW     = 3;
  localparam int unsigned MaxResults     = 4;
  localparam int unsigned QueueDepthDef  = 2;
  localparam logic [2:0]  MaxFieldsReset = 3'd4;
  localparam logic [2:0]  MaxFieldsCap   = 3'd4;
  localparam logic [3:0]  MaxLength      = 4'd8;

  localparam logic [10:0] LssIdMaster = 11'h7E4;
  localparam logic [10:0] LssIdSlave  = 11'h7E5;
  localparam logic [7:0]  SdoAbortCs  = 8'h80;

  typedef enum logic [4:0] {
    ClsInvalid = 5'd0,
    ClsNmt     = 5'd1,
    ClsSync    = 5'd2,
    ClsEmcy    = 5'd3,
    ClsTime    = 5'd4,
    ClsLss     = 5'd5,
    ClsTpdo1   = 5'd6,
    ClsRpdo1   = 5'd7,
    ClsTpdo2   = 5'd8,
    ClsRpdo2   = 5'd9,
    ClsTpdo3   = 5'd10,
    ClsRpdo3   = 5'd11,
    ClsTpdo4   = 5'd12,
    ClsRpdo4   = 5'd13,
    ClsSdoTx   = 5'd14,
    ClsSdoRx   = 5'd15,
    ClsHbeat   = 5'd16
  } class_e;

  typedef enum logic [3:0] {
    KindNone    = 4'd0,
    KindCommand = 4'd1,
    KindTarget  = 4'd2,
    KindCounter = 4'd3,
    KindErrCode = 4'd4,
    KindErrReg  = 4'd5,
    KindState   = 4'd6,
    KindCs      = 4'd7,
    KindIndex   = 4'd8,
    KindSub     = 4'd9,
    KindAbort   = 4'd10
  } kind_e;

  typedef enum logic [4:0] {
    LblNone         = 5'd0,
    LblStart        = 5'd1,
    LblStop         = 5'd2,
    LblPreOpCmd     = 5'd3,
    LblResetNode    = 5'd4,
    LblResetComm    = 5'd5,
    LblBootUp       = 5'd6,
    LblStopped      = 5'd7,
    LblOperational  = 5'd8,
    LblPreOpState   = 5'd9,
    LblDnSeg        = 5'd10,
    LblDnInit       = 5'd11,
    LblUpInit       = 5'd12,
    LblUpSeg        = 5'd13,
    LblAbort        = 5'd14,
    LblBlkUp        = 5'd15,
    LblBlkDn        = 5'd16,
    LblUpSegResp    = 5'd17,
    LblDnSegResp    = 5'd18,
    LblUpInitResp   = 5'd19,
    LblDnInitResp   = 5'd20,
    LblBlkDnResp    = 5'd21,
    LblBlkUpResp    = 5'd22
  } label_e;

  // One classified frame with its field list, as held in the queue.
  typedef struct packed {
    class_e                 cls;
    logic [6:0]             node;
    logic [2:0]             count;   // fields to emit, 0 means a single none result
    logic [3:0][3:0]        kind;
    logic [3:0][4:0]        label;
    logic [3:0][31:0]       value;
  } rec_t;

  function automatic class_e classify(input logic [28:0] id, input logic ext);
    logic [3:0] fc;
    logic [6:0] node;
    class_e     cls;
    fc   = id[10:7];
    node = id[6:0];
    if (ext || (id[28:11] != 18'd0)) begin
      cls = ClsInvalid;
    end else if (fc == 4'd0) begin
      cls = (node == 7'd0) ? ClsNmt : ClsInvalid;
    end else if (fc == 4'd1) begin
      cls = (node == 7'd0) ? ClsSync : ClsEmcy;
    end else if (fc == 4'd2) begin
      cls = (node == 7'd0) ? ClsTime : ClsInvalid;
    end else if ((id[10:0] == LssIdMaster) || (id[10:0] == LssIdSlave)) begin
      cls = ClsLss;
    end else if (node == 7'd0) begin
      cls = ClsInvalid;
    end else if ((fc >= 4'd3) && (fc <= 4'd12)) begin
      cls = class_e'({1'b0, fc} + 5'd3);
    end else if (fc == 4'd14) begin
      cls = ClsHbeat;
    end else begin
      cls = ClsInvalid;
    end
    return cls;
  endfunction

  function automatic label_e nmt_cmd_label(input logic [7:0] b);
    label_e l;
    unique case (b)
      8'h01:   l = LblStart;
      8'h02:   l = LblStop;
      8'h80:   l = LblPreOpCmd;
      8'h81:   l = LblResetNode;
      8'h82:   l = LblResetComm;
      default: l = LblNone;
    endcase
    return l;
  endfunction

  // Bit 7 is the toggle bit and takes no part in the state.
  function automatic label_e nmt_state_label(input logic [7:0] b);
    label_e l;
    unique case (b[6:0])
      7'h00:   l = LblBootUp;
      7'h04:   l = LblStopped;
      7'h05:   l = LblOperational;
      7'h7F:   l = LblPreOpState;
      default: l = LblNone;
    endcase
    return l;
  endfunction

  function automatic label_e sdo_label(input logic [7:0] b, input logic server);
    label_e l;
    if (server) begin
      unique case (b[7:5])
        3'd0:    l = LblUpSegResp;
        3'd1:    l = LblDnSegResp;
        3'd2:    l = LblUpInitResp;
        3'd3:    l = LblDnInitResp;
        3'd4:    l = LblAbort;
        3'd5:    l = LblBlkDnResp;
        3'd6:    l = LblBlkUpResp;
        default: l = LblNone;
      endcase
    end else begin
      unique case (b[7:5])
        3'd0:    l = LblDnSeg;
        3'd1:    l = LblDnInit;
        3'd2:    l = LblUpInit;
        3'd3:    l = LblUpSeg;
        3'd4:    l = LblAbort;
        3'd5:    l = LblBlkUp;
        3'd6:    l = LblBlkDn;
        default: l = LblNone;
      endcase
    end
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cofd_frame_if.sv
// Input channel carrying one CAN frame per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface cofd_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] cob_id;
  logic        extended;
  logic [3:0]  length;
  logic [63:0] payload;

  modport source (output valid, cob_id, extended, length, payload, input ready);
  modport sink   (input valid, cob_id, extended, length, payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cofd_field_if.sv
// Output channel carrying one decoded field result per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface cofd_field_if;
  logic        valid;
  logic        ready;
  logic [4:0]  frame_class;
  logic [6:0]  node_number;
  logic [3:0]  field_kind;
  logic [4:0]  label_code;
  logic [31:0] field_value;
  logic        last_field;

  modport source (output valid, frame_class, node_number, field_kind, label_code,
                  field_value, last_field, input ready);
  modport sink   (input valid, frame_class, node_number, field_kind, label_code,
                  field_value, last_field, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cofd_front.sv
// Front end: accepts frames, classifies them and builds the field list.
// Depends on cofd_pkg and cofd_frame_if.
`timescale 1ns / 1ps
`default_nettype none

module cofd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_wdata_i,
  cofd_frame_if.sink                frame_i,
  input  wire logic                 q_full_i,
  output      logic                 push_o,
  output      cofd_pkg::rec_t       rec_o
);

  logic [2:0]         max_fields_q;
  logic [2:0]         cap;
  logic [2:0]         n_c;
  logic [3:0]         len_c;
  logic [7:0]         b0, b1, b2, b3;
  cofd_pkg::class_e   cls_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= cofd_pkg::MaxFieldsReset;
    end else if (cfg_we_i) begin
      max_fields_q <= cfg_wdata_i;
    end
  end

  assign frame_i.ready = !q_full_i;
  assign push_o        = frame_i.valid && !q_full_i;

  assign b0 = frame_i.payload[7:0];
  assign b1 = frame_i.payload[15:8];
  assign b2 = frame_i.payload[23:16];
  assign b3 = frame_i.payload[31:24];

  always_comb begin
    len_c = (frame_i.length > cofd_pkg::MaxLength) ? cofd_pkg::MaxLength : frame_i.length;
    cls_c = cofd_pkg::classify(frame_i.cob_id, frame_i.extended);
    cap   = (max_fields_q > cofd_pkg::MaxFieldsCap) ? cofd_pkg::MaxFieldsCap : max_fields_q;

    rec_o       = '0;
    rec_o.cls   = cls_c;
    rec_o.node  = frame_i.cob_id[6:0];
    n_c         = 3'd0;

    unique case (cls_c)
      cofd_pkg::ClsNmt: begin
        if (len_c >= 4'd2) begin
          rec_o.kind[0]  = cofd_pkg::KindCommand;
          rec_o.label[0] = cofd_pkg::nmt_cmd_label(b0);
          rec_o.value[0] = {24'd0, b0};
          rec_o.kind[1]  = cofd_pkg::KindTarget;
          rec_o.value[1] = {24'd0, b1};
          n_c            = 3'd2;
        end
      end
      cofd_pkg::ClsSync: begin
        if (len_c >= 4'd1) begin
          rec_o.kind[0]  = cofd_pkg::KindCounter;
          rec_o.value[0] = {24'd0, b0};
          n_c            = 3'd1;
        end
      end
      cofd_pkg::ClsEmcy: begin
        if (len_c >= 4'd3) begin
          rec_o.kind[0]  = cofd_pkg::KindErrCode;
          rec_o.value[0] = {16'd0, b1, b0};
          rec_o.kind[1]  = cofd_pkg::KindErrReg;
          rec_o.value[1] = {24'd0, b2};
          n_c            = 3'd2;
        end
      end
      cofd_pkg::ClsHbeat: begin
        if (len_c >= 4'd1) begin
          rec_o.kind[0]  = cofd_pkg::KindState;
          rec_o.label[0] = cofd_pkg::nmt_state_label(b0);
          rec_o.value[0] = {24'd0, b0};
          n_c            = 3'd1;
        end
      end
      cofd_pkg::ClsSdoTx, cofd_pkg::ClsSdoRx: begin
        if (len_c >= 4'd4) begin
          rec_o.kind[0]  = cofd_pkg::KindCs;
          rec_o.label[0] = cofd_pkg::sdo_label(b0, cls_c == cofd_pkg::ClsSdoTx);
          rec_o.value[0] = {24'd0, b0};
          rec_o.kind[1]  = cofd_pkg::KindIndex;
          rec_o.value[1] = {16'd0, b2, b1};
          rec_o.kind[2]  = cofd_pkg::KindSub;
          rec_o.value[2] = {24'd0, b3};
          n_c            = 3'd3;
          if ((b0 == cofd_pkg::SdoAbortCs) && (len_c >= 4'd8)) begin
            rec_o.kind[3]  = cofd_pkg::KindAbort;
            rec_o.value[3] = frame_i.payload[63:32];
            n_c            = 3'd4;
          end
        end
      end
      default: begin
        n_c = 3'd0;
      end
    endcase

    rec_o.count = (n_c < cap) ? n_c : cap;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cofd_queue.sv
// Short queue of classified frames between front end and back end.
// Depends on cofd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cofd_queue #(
  parameter int unsigned Depth = cofd_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire cofd_pkg::rec_t   rec_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      cofd_pkg::rec_t   rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cofd_pkg::rec_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cofd_back.sv
// Back end: walks the field list of the head frame, one result per beat.
// Depends on cofd_pkg and cofd_field_if.
`timescale 1ns / 1ps
`default_nettype none

module cofd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire cofd_pkg::rec_t   rec_i,
  output      logic             pop_o,
  cofd_field_if.source          field_o
);

  logic        out_valid_q, out_valid_d;
  logic [1:0]  idx_q, idx_d;
  logic        load;
  logic        last_c;
  logic        none_c;

  logic [4:0]  cls_q;
  logic [6:0]  node_q;
  logic [3:0]  kind_q;
  logic [4:0]  label_q;
  logic [31:0] value_q;
  logic        last_q;

  assign load   = !out_valid_q || field_o.ready;
  assign none_c = (rec_i.count == 3'd0);
  assign last_c = none_c || (({1'b0, idx_q} + 3'd1) == rec_i.count);
  assign pop_o  = load && q_valid_i && last_c;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        idx_d = last_c ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      cls_q   <= rec_i.cls;
      node_q  <= rec_i.node;
      kind_q  <= none_c ? 4'(cofd_pkg::KindNone) : rec_i.kind[idx_q];
      label_q <= none_c ? 5'(cofd_pkg::LblNone)  : rec_i.label[idx_q];
      value_q <= none_c ? 32'd0                  : rec_i.value[idx_q];
      last_q  <= last_c;
    end
  end

  assign field_o.valid       = out_valid_q;
  assign field_o.frame_class = cls_q;
  assign field_o.node_number = node_q;
  assign field_o.field_kind  = kind_q;
  assign field_o.label_code  = label_q;
  assign field_o.field_value = value_q;
  assign field_o.last_field  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/canopen_frame_decoder.sv
// CANopen frame decoder: one frame in, one to four field results out.
// The first result of a frame passes through a queue entry and then the
// output register before its output beat.
// Throughput: one result per cycle at the output register while the output is
// ready; the frame queue lets the front keep accepting until it is full, and the
// front stalls while the queue is full, also in the cycle where it drops its head.
// Reset: max_fields returns to 4, the frame queue empties, no result is valid.
`timescale 1ns / 1ps
`default_nettype none

module canopen_frame_decoder #(
  parameter int unsigned QueueDepth = cofd_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // max_fields register, written on any beat of the write enable
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  cofd_frame_if.sink       frame_i,
  cofd_field_if.source     field_o
);

  // Front to queue: one classified frame, pushed when the queue has room.
  logic            push;
  cofd_pkg::rec_t  front_rec;
  logic            q_full;

  // Queue to back: the head frame, dropped once its final result is loaded.
  logic            q_valid;
  cofd_pkg::rec_t  head_rec;
  logic            pop;

  // Classify the frame and build its field list in the accepting cycle.
  cofd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  // Hold decoded frames so that a stalled output does not stop the front.
  cofd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  // Advance through the head frame's fields into the output register.
  cofd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .rec_i     (head_rec),
    .pop_o     (pop),
    .field_o   (field_o)
  );

endmodule

`default_nettype wire
